### sv/lav_pkg.sv
package lav_pkg;

   // 1.0 in Q16.16, the fixed corner entry of the view matrix.
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   // One accepted camera pose as it waits for the back end.
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][32:0] dir;
      logic [2:0][31:0] upv;
      logic             skip;
   } pose_type;

   // Request and answer of the shared normalize unit.
   typedef struct packed {
      logic             start;
      logic [2:0][34:0] vec;
   } norm_req_type;

   typedef struct packed {
      logic             done;
      logic             zero;
      logic [2:0][17:0] unit;
   } norm_rsp_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_SHIFT,
      U_SQUARE,
      U_ROOT,
      U_LOAD,
      U_DIV
   } unit_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_NORM_F,
      B_NORM_U,
      B_CROSS_FU,
      B_NORM_S,
      B_CROSS_SF,
      B_DOT,
      B_EMIT
   } back_state_type;

   // Cyclic successors of a vector component index.
   function automatic logic [1:0] next1(input logic [1:0] i);
      logic [1:0] r;
      case (i)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] next2(input logic [1:0] i);
      logic [1:0] r;
      case (i)
         2'd0:    r = 2'd2;
         2'd1:    r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

endpackage

### sv/look_at_view_matrix.sv
// Look-at view matrix in Q16.16 fixed point.
// The req_ channel takes one camera pose per transaction: position, look
// target and up vector, three signed Q16.16 components each. The rsp_ channel
// returns four transactions per pose, matrix rows 0 to 3 in order, with
// rsp_last_row set on row 3 and rsp_degenerate set (all entries zero) when the
// forward, up or side axis cannot be normalized.
// A front stage forms the forward difference and flags zero vectors, then a
// two-entry queue holds poses for the back end, so req_ready stays high while
// the back end is busy unless the queue is full.
// The back end runs the three normalizations on one shared iterative unit
// (bit-serial square root and restoring division) and takes the next pose from
// the queue only after the last row of the current pose has been loaded.
// A degenerate pose flagged at the front skips the arithmetic and goes straight
// to emitting its four rows.
// Reset is synchronous and active high; it empties the queue and drops any
// pose in flight. When the receiver stalls, the current row holds in the
// output register and the back end waits; new poses still fill the queue.
module look_at_view_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_aim_x,
   input  logic signed [31:0] req_aim_y,
   input  logic signed [31:0] req_aim_z,
   input  logic signed [31:0] req_upv_x,
   input  logic signed [31:0] req_upv_y,
   input  logic signed [31:0] req_upv_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_col_a,
   output logic signed [31:0] rsp_col_b,
   output logic signed [31:0] rsp_col_c,
   output logic signed [31:0] rsp_col_d,
   output logic               rsp_last_row,
   output logic               rsp_degenerate
);

   // Handshake between the front end, the queue and the back end.
   logic              q_full;
   logic              q_push;
   logic              q_pop;
   logic              q_valid;
   lav_pkg::pose_type push_pose;
   lav_pkg::pose_type head_pose;

   // The front end is combinational: it classifies the pose as it enters.
   lav_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_pos_z (req_pos_z),
      .req_aim_x (req_aim_x),
      .req_aim_y (req_aim_y),
      .req_aim_z (req_aim_z),
      .req_upv_x (req_upv_x),
      .req_upv_y (req_upv_y),
      .req_upv_z (req_upv_z),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_pose    (push_pose)
   );

   // The queue lets the front accept while the back end computes.
   lav_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_pose  (push_pose),
      .full     (q_full),
      .pop      (q_pop),
      .rd_valid (q_valid),
      .rd_pose  (head_pose)
   );

   // The back end normalizes, forms the cross and dot products and emits rows.
   lav_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pose         (head_pose),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_index  (rsp_row_index),
      .rsp_col_a      (rsp_col_a),
      .rsp_col_b      (rsp_col_b),
      .rsp_col_c      (rsp_col_c),
      .rsp_col_d      (rsp_col_d),
      .rsp_last_row   (rsp_last_row),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

### sv/lav_front.sv
module lav_front (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic signed [31:0]  req_aim_x,
   input  logic signed [31:0]  req_aim_y,
   input  logic signed [31:0]  req_aim_z,
   input  logic signed [31:0]  req_upv_x,
   input  logic signed [31:0]  req_upv_y,
   input  logic signed [31:0]  req_upv_z,
   input  logic                q_full,
   output logic                q_push,
   output lav_pkg::pose_type   q_pose
);

   logic [2:0][31:0] pos;
   logic [2:0][31:0] aim;

   assign pos = {req_pos_z, req_pos_y, req_pos_x};
   assign aim = {req_aim_z, req_aim_y, req_aim_x};

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // The forward difference is exact in 33 bits. A pose whose forward or up
   // vector is zero is marked here so the back end skips the arithmetic.
   always_comb begin
      q_pose.pos = pos;
      q_pose.upv = {req_upv_z, req_upv_y, req_upv_x};
      for (int i = 0; i < 3; i++) begin
         q_pose.dir[i] = {aim[i][31], aim[i]} - {pos[i][31], pos[i]};
      end
      q_pose.skip = (q_pose.dir == '0) || (q_pose.upv == '0);
   end

endmodule

### sv/lav_queue.sv
module lav_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lav_pkg::pose_type wr_pose,
   output logic              full,
   input  logic              pop,
   output logic              rd_valid,
   output lav_pkg::pose_type rd_pose
);

   lav_pkg::pose_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_pose  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop && rd_valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if ((push && !full) && !(pop && rd_valid)) begin
         count_in = count_ff + 2'd1;
      end else if (!(push && !full) && (pop && rd_valid)) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= wr_pose;
      end
   end

endmodule

### sv/lav_norm.sv
module lav_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  lav_pkg::norm_req_type req,
   output lav_pkg::norm_rsp_type rsp
);

   lav_pkg::unit_state_type state_ff, state_in;
   logic [2:0][34:0] mag_ff, mag_in;
   logic [2:0]       neg_ff, neg_in;
   logic [61:0]      sum_ff, sum_in;
   logic [63:0]      x_ff, x_in;
   logic [63:0]      res_ff, res_in;
   logic [4:0]       k_ff, k_in;
   logic [1:0]       idx_ff, idx_in;
   logic [48:0]      rem_ff, rem_in;
   logic [48:0]      dsh_ff, dsh_in;
   logic [16:0]      q_ff, q_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [2:0][17:0] unit_ff, unit_in;
   logic             done_ff, done_in;
   logic             zero_ff, zero_in;

   logic [34:0] m01, mx;
   logic [59:0] sq;
   logic [63:0] bitv, trial;
   logic        ge;

   assign rsp.done = done_ff;
   assign rsp.zero = zero_ff;
   assign rsp.unit = unit_ff;

   assign m01   = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign mx    = (m01 > mag_ff[2]) ? m01 : mag_ff[2];
   assign sq    = mag_ff[idx_ff][29:0] * mag_ff[idx_ff][29:0];
   assign bitv  = 64'd1 << {k_ff, 1'b0};
   assign trial = res_ff + bitv;
   assign ge    = (rem_ff >= dsh_ff);

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      sum_in   = sum_ff;
      x_in     = x_ff;
      res_in   = res_ff;
      k_in     = k_ff;
      idx_in   = idx_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      unit_in  = unit_ff;
      done_in  = 1'b0;
      zero_in  = zero_ff;
      unique case (state_ff)
         lav_pkg::U_IDLE: begin
            if (req.start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = req.vec[i][34];
                  mag_in[i] = req.vec[i][34] ? (35'd0 - req.vec[i]) : req.vec[i];
               end
               if (req.vec == '0) begin
                  done_in = 1'b1;
                  zero_in = 1'b1;
               end else begin
                  state_in = lav_pkg::U_SHIFT;
               end
            end
         end
         lav_pkg::U_SHIFT: begin
            // Bring the largest magnitude into [2^29, 2^30), one bit a cycle.
            if (mx[34:30] != 5'd0) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (!mx[29]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               state_in = lav_pkg::U_SQUARE;
               idx_in   = 2'd0;
               sum_in   = '0;
            end
         end
         lav_pkg::U_SQUARE: begin
            sum_in = sum_ff + {2'b00, sq};
            if (idx_ff == 2'd2) begin
               state_in = lav_pkg::U_ROOT;
               x_in     = {2'b00, sum_in};
               res_in   = '0;
               k_in     = 5'd31;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         lav_pkg::U_ROOT: begin
            // Digit-by-digit integer square root, one result bit a cycle.
            if (x_ff >= trial) begin
               x_in   = x_ff - trial;
               res_in = (res_ff >> 1) + bitv;
            end else begin
               res_in = res_ff >> 1;
            end
            if (k_ff == 5'd0) begin
               state_in = lav_pkg::U_LOAD;
               idx_in   = 2'd0;
            end else begin
               k_in = k_ff - 5'd1;
            end
         end
         lav_pkg::U_LOAD: begin
            rem_in   = {2'b00, mag_ff[idx_ff][29:0], 17'd0} + {18'd0, res_ff[30:0]};
            dsh_in   = {1'b0, res_ff[30:0], 17'd0};
            q_in     = '0;
            cnt_in   = 5'd16;
            state_in = lav_pkg::U_DIV;
         end
         lav_pkg::U_DIV: begin
            // Restoring division by twice the root; the quotient fits 17 bits.
            rem_in = ge ? (rem_ff - dsh_ff) : rem_ff;
            dsh_in = dsh_ff >> 1;
            q_in   = {q_ff[15:0], ge};
            if (cnt_ff == 5'd0) begin
               unit_in[idx_ff] = neg_ff[idx_ff] ? (18'd0 - {1'b0, q_in}) : {1'b0, q_in};
               if (idx_ff == 2'd2) begin
                  state_in = lav_pkg::U_IDLE;
                  done_in  = 1'b1;
                  zero_in  = 1'b0;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = lav_pkg::U_LOAD;
               end
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         default: begin
            state_in = lav_pkg::U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lav_pkg::U_IDLE;
         done_ff  <= 1'b0;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         zero_ff  <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      sum_ff  <= sum_in;
      x_ff    <= x_in;
      res_ff  <= res_in;
      k_ff    <= k_in;
      idx_ff  <= idx_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      unit_ff <= unit_in;
   end

endmodule

### sv/lav_back.sv
module lav_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  lav_pkg::pose_type q_pose,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_row_index,
   output logic signed [31:0] rsp_col_a,
   output logic signed [31:0] rsp_col_b,
   output logic signed [31:0] rsp_col_c,
   output logic signed [31:0] rsp_col_d,
   output logic              rsp_last_row,
   output logic              rsp_degenerate
);

   lav_pkg::back_state_type state_ff, state_in;
   lav_pkg::pose_type       cur_ff, cur_in;
   lav_pkg::norm_req_type   nreq;
   lav_pkg::norm_rsp_type   nrsp;

   logic             wait_ff, wait_in;
   logic             deg_ff, deg_in;
   logic [2:0][17:0] f_ff, f_in, u_ff, u_in, s_ff, s_in;
   logic [2:0][19:0] t_ff, t_in;
   logic [2:0][34:0] c_ff, c_in;
   logic [2:0][31:0] tr_ff, tr_in;
   logic [1:0]       comp_ff, comp_in, term_ff, term_in;
   logic [55:0]      acc_ff, acc_in;
   logic [1:0]       row_ff, row_in;

   logic             valid_ff, valid_in;
   logic [1:0]       o_row_ff, o_row_in;
   logic [31:0]      o_a_ff, o_a_in, o_b_ff, o_b_in, o_c_ff, o_c_in, o_d_ff, o_d_in;
   logic             o_last_ff, o_last_in, o_deg_ff, o_deg_in;

   logic signed [19:0] opa;
   logic signed [31:0] opb;
   logic signed [51:0] prod;
   logic [55:0]        prod_x, acc_next, dot_v;
   logic [1:0]         i1, i2;
   logic               load;

   lav_norm u_norm (
      .clock (clock),
      .reset (reset),
      .req   (nreq),
      .rsp   (nrsp)
   );

   function automatic logic [40:0] round16(input logic [55:0] v);
      logic [55:0] mag;
      logic [39:0] q;
      mag = v[55] ? (56'd0 - v) : v;
      q   = 40'((mag + 56'd32768) >> 16);
      return v[55] ? (41'd0 - {1'b0, q}) : {1'b0, q};
   endfunction

   function automatic logic [31:0] sat32(input logic [40:0] v);
      logic [31:0] r;
      if (!v[40] && (v[39:31] != 9'd0)) begin
         r = 32'h7FFF_FFFF;
      end else if (v[40] && (v[39:31] != 9'h1FF)) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   assign i1 = lav_pkg::next1(comp_ff);
   assign i2 = lav_pkg::next2(comp_ff);

   // Operand selection for the shared multiply-accumulate.
   always_comb begin
      opa = '0;
      opb = '0;
      case (state_ff)
         lav_pkg::B_CROSS_FU: begin
            opa = (term_ff == 2'd0) ? 20'(signed'(f_ff[i1])) : 20'(signed'(f_ff[i2]));
            opb = (term_ff == 2'd0) ? 32'(signed'(u_ff[i2])) : 32'(signed'(u_ff[i1]));
         end
         lav_pkg::B_CROSS_SF: begin
            opa = (term_ff == 2'd0) ? 20'(signed'(s_ff[i1])) : 20'(signed'(s_ff[i2]));
            opb = (term_ff == 2'd0) ? 32'(signed'(f_ff[i2])) : 32'(signed'(f_ff[i1]));
         end
         lav_pkg::B_DOT: begin
            case (comp_ff)
               2'd0:    opa = 20'(signed'(s_ff[term_ff]));
               2'd1:    opa = signed'(t_ff[term_ff]);
               default: opa = 20'(signed'(f_ff[term_ff]));
            endcase
            opb = signed'(cur_ff.pos[term_ff]);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign prod   = opa * opb;
   assign prod_x = 56'(prod);
   always_comb begin
      if (state_ff == lav_pkg::B_DOT) begin
         acc_next = ((term_ff == 2'd0) ? 56'd0 : acc_ff) + prod_x;
      end else begin
         acc_next = (term_ff == 2'd0) ? prod_x : (acc_ff - prod_x);
      end
   end
   // Side and true-up translations are negated dot products.
   assign dot_v = (comp_ff == 2'd2) ? acc_next : (56'd0 - acc_next);

   assign load = (state_ff == lav_pkg::B_EMIT) && (!valid_ff || rsp_ready);

   always_comb begin
      nreq.start = !wait_ff && ((state_ff == lav_pkg::B_NORM_F) ||
                                (state_ff == lav_pkg::B_NORM_U) ||
                                (state_ff == lav_pkg::B_NORM_S));
      for (int i = 0; i < 3; i++) begin
         case (state_ff)
            lav_pkg::B_NORM_F: nreq.vec[i] = {{2{cur_ff.dir[i][32]}}, cur_ff.dir[i]};
            lav_pkg::B_NORM_U: nreq.vec[i] = {{3{cur_ff.upv[i][31]}}, cur_ff.upv[i]};
            default:           nreq.vec[i] = c_ff[i];
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      wait_in  = wait_ff;
      deg_in   = deg_ff;
      f_in     = f_ff;
      u_in     = u_ff;
      s_in     = s_ff;
      t_in     = t_ff;
      c_in     = c_ff;
      tr_in    = tr_ff;
      comp_in  = comp_ff;
      term_in  = term_ff;
      acc_in   = acc_ff;
      row_in   = row_ff;
      q_pop    = 1'b0;
      if (nreq.start) begin
         wait_in = 1'b1;
      end
      if (nrsp.done) begin
         wait_in = 1'b0;
      end
      unique case (state_ff)
         lav_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_pose;
               deg_in   = q_pose.skip;
               row_in   = 2'd0;
               state_in = q_pose.skip ? lav_pkg::B_EMIT : lav_pkg::B_NORM_F;
            end
         end
         lav_pkg::B_NORM_F: begin
            if (nrsp.done) begin
               f_in     = nrsp.unit;
               deg_in   = nrsp.zero;
               state_in = nrsp.zero ? lav_pkg::B_EMIT : lav_pkg::B_NORM_U;
            end
         end
         lav_pkg::B_NORM_U: begin
            if (nrsp.done) begin
               u_in     = nrsp.unit;
               deg_in   = nrsp.zero;
               comp_in  = 2'd0;
               term_in  = 2'd0;
               state_in = nrsp.zero ? lav_pkg::B_EMIT : lav_pkg::B_CROSS_FU;
            end
         end
         lav_pkg::B_CROSS_FU: begin
            acc_in = acc_next;
            if (term_ff == 2'd1) begin
               c_in[comp_ff] = acc_next[34:0];
               term_in       = 2'd0;
               comp_in       = comp_ff + 2'd1;
               if (comp_ff == 2'd2) begin
                  state_in = lav_pkg::B_NORM_S;
               end
            end else begin
               term_in = 2'd1;
            end
         end
         lav_pkg::B_NORM_S: begin
            if (nrsp.done) begin
               s_in     = nrsp.unit;
               deg_in   = nrsp.zero;
               comp_in  = 2'd0;
               term_in  = 2'd0;
               state_in = nrsp.zero ? lav_pkg::B_EMIT : lav_pkg::B_CROSS_SF;
            end
         end
         lav_pkg::B_CROSS_SF: begin
            acc_in = acc_next;
            if (term_ff == 2'd1) begin
               t_in[comp_ff] = 20'(round16(acc_next));
               term_in       = 2'd0;
               comp_in       = comp_ff + 2'd1;
               if (comp_ff == 2'd2) begin
                  comp_in  = 2'd0;
                  state_in = lav_pkg::B_DOT;
               end
            end else begin
               term_in = 2'd1;
            end
         end
         lav_pkg::B_DOT: begin
            acc_in = acc_next;
            if (term_ff == 2'd2) begin
               tr_in[comp_ff] = sat32(round16(dot_v));
               term_in        = 2'd0;
               comp_in        = comp_ff + 2'd1;
               if (comp_ff == 2'd2) begin
                  row_in   = 2'd0;
                  state_in = lav_pkg::B_EMIT;
               end
            end else begin
               term_in = term_ff + 2'd1;
            end
         end
         lav_pkg::B_EMIT: begin
            if (load) begin
               row_in = row_ff + 2'd1;
               if (row_ff == 2'd3) begin
                  state_in = lav_pkg::B_IDLE;
               end
            end
         end
         default: begin
            state_in = lav_pkg::B_IDLE;
         end
      endcase
   end

   // Output register: one matrix row per transaction.
   always_comb begin
      o_row_in  = o_row_ff;
      o_a_in    = o_a_ff;
      o_b_in    = o_b_ff;
      o_c_in    = o_c_ff;
      o_d_in    = o_d_ff;
      o_last_in = o_last_ff;
      o_deg_in  = o_deg_ff;
      valid_in  = valid_ff && !rsp_ready;
      if (load) begin
         valid_in  = 1'b1;
         o_row_in  = row_ff;
         o_last_in = (row_ff == 2'd3);
         o_deg_in  = deg_ff;
         if (deg_ff) begin
            o_a_in = '0;
            o_b_in = '0;
            o_c_in = '0;
            o_d_in = '0;
         end else if (row_ff == 2'd3) begin
            o_a_in = tr_ff[0];
            o_b_in = tr_ff[1];
            o_c_in = tr_ff[2];
            o_d_in = lav_pkg::ONE_Q16;
         end else begin
            o_a_in = 32'(signed'(s_ff[row_ff]));
            o_b_in = 32'(signed'(t_ff[row_ff]));
            o_c_in = 32'd0 - 32'(signed'(f_ff[row_ff]));
            o_d_in = '0;
         end
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_row_index  = o_row_ff;
   assign rsp_col_a      = signed'(o_a_ff);
   assign rsp_col_b      = signed'(o_b_ff);
   assign rsp_col_c      = signed'(o_c_ff);
   assign rsp_col_d      = signed'(o_d_ff);
   assign rsp_last_row   = o_last_ff;
   assign rsp_degenerate = o_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lav_pkg::B_IDLE;
         wait_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      deg_ff    <= deg_in;
      f_ff      <= f_in;
      u_ff      <= u_in;
      s_ff      <= s_in;
      t_ff      <= t_in;
      c_ff      <= c_in;
      tr_ff     <= tr_in;
      comp_ff   <= comp_in;
      term_ff   <= term_in;
      acc_ff    <= acc_in;
      row_ff    <= row_in;
      o_row_ff  <= o_row_in;
      o_a_ff    <= o_a_in;
      o_b_ff    <= o_b_in;
      o_c_ff    <= o_c_in;
      o_d_ff    <= o_d_in;
      o_last_ff <= o_last_in;
      o_deg_ff  <= o_deg_in;
   end

endmodule
